### sv/sorted_keyframe_table_unit_macros.svh
// Assertion macros shared by the checker of the keyframe table.
// Used by skt_checker only; no other dependencies.
`ifndef SORTED_KEYFRAME_TABLE_UNIT_MACROS_SVH
`define SORTED_KEYFRAME_TABLE_UNIT_MACROS_SVH
// Implication checked every clock edge outside reset.
`define SKT_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("same cycle");
`define SKT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("next");
`endif

### sv/skt_pkg.sv
// Types and codes of the sorted keyframe table.
// No dependencies.
package skt_pkg;
  localparam int TimeW = 32;
  localparam int WordW = 32;
  localparam int CodeW = 3;
  localparam int IndexW = 6;
  localparam int CountW = 7;

  typedef enum logic [2:0] {
    ACT_FIND  = 3'd0,
    ACT_FLOOR = 3'd1,
    ACT_SET   = 3'd2,
    ACT_REM   = 3'd3,
    ACT_MOVE  = 3'd4,
    ACT_CURVE = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  localparam logic CFG_BEZIER = 1'b0;
  localparam logic CFG_CUSTOM = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_EXEC, S_SEARCH2, S_EXEC2, S_DONE
  } fsm_t;

  // Input word.
  typedef struct packed {
    logic [2:0]       action;
    logic [TimeW-1:0] key_time;
    logic [TimeW-1:0] dest_time;
    logic [WordW-1:0] key_value;
    logic [CodeW-1:0] interp_code;
    logic [WordW-1:0] ctrl_x1;
    logic [WordW-1:0] ctrl_y1;
    logic [WordW-1:0] ctrl_x2;
    logic [WordW-1:0] ctrl_y2;
  } edit_t;

  // Result word.
  typedef struct packed {
    logic [1:0]        status;
    logic [IndexW-1:0] entry_index;
    logic [CountW-1:0] entry_count;
  } reply_t;

  // Configuration write word.
  typedef struct packed {
    logic             index;
    logic [CodeW-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] t;
    logic [WordW-1:0] v;
    logic [CodeW-1:0] c;
    logic [WordW-1:0] x1;
    logic [WordW-1:0] y1;
    logic [WordW-1:0] x2;
    logic [WordW-1:0] y2;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_INSERT, OP_ERASE, OP_SETVAL, OP_CURVE
  } cellop_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cellop_t          op;
    logic [TimeW-1:0] key;
    entry_t           ent;
    logic             wr_ctrl;
  } bcast_t;
endpackage

### sv/skt_if.sv
// Valid/ready channel carrying one word of type T.
// Depends on nothing.
interface skt_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/skt_cell.sv
// One slot of the table: holds an entry and compares it to the broadcast key.
// Depends on skt_pkg.
module skt_cell (
  input  logic            clk,
  input  logic            rst,
  input  skt_pkg::bcast_t bc,
  input  logic            sel,
  input  logic            shift_in,
  input  logic            shift_out,
  input  skt_pkg::entry_t left,
  input  skt_pkg::entry_t right,
  input  logic            used,
  output skt_pkg::entry_t ent,
  output logic            eq,
  output logic            lt
);
  // Times are biased so unsigned order follows signed order.
  logic [skt_pkg::TimeW-1:0] kb, tb;

  assign tb = ent.t ^ {1'b1, {(skt_pkg::TimeW-1){1'b0}}};
  assign kb = bc.key ^ {1'b1, {(skt_pkg::TimeW-1){1'b0}}};
  assign eq = used && (tb == kb);
  assign lt = used && (tb < kb);

  always_ff @(posedge clk) begin
    if (!rst) begin
      case (bc.op)
        skt_pkg::OP_INSERT: begin
          if (sel) ent <= bc.ent;
          else if (shift_in) ent <= left;
        end
        skt_pkg::OP_ERASE: begin
          if (shift_out) ent <= right;
        end
        skt_pkg::OP_SETVAL: begin
          if (sel) ent.v <= bc.ent.v;
        end
        skt_pkg::OP_CURVE: begin
          if (sel) begin
            ent.c <= bc.ent.c;
            if (bc.wr_ctrl) begin
              ent.x1 <= bc.ent.x1;
              ent.y1 <= bc.ent.y1;
              ent.x2 <= bc.ent.x2;
              ent.y2 <= bc.ent.y2;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### sv/sorted_keyframe_table_unit.sv
// A word is accepted in S_IDLE, searched in S_SEARCH and executed in S_EXEC;
// a move that relocates a key also passes S_SEARCH2 and S_EXEC2. The result
// waits in S_DONE until taken, and no new word is accepted meanwhile; compares
// run in parallel across the cell chain; each edit shifts the whole chain at once.
// Reset (synchronous, rst high) empties the table and loads code registers 2 and 3.
// Stored entries are not cleared; cells above the key count are never read.
module sorted_keyframe_table_unit #(
  parameter int MAX_KEYS = 64
) (
  input  logic clk,
  input  logic rst,
  skt_if.sink   cfg,
  skt_if.sink   in_ch,
  skt_if.source out_ch
);
  localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);

  skt_pkg::fsm_t  state, state_next;
  skt_pkg::edit_t req;
  logic [CW-1:0] count, count_next;
  logic [2:0]    bezier_code, custom_curve_code;
  logic [1:0]    st, st_next;
  logic [IW-1:0] idx, idx_next;
  logic          out_valid;

  skt_pkg::entry_t ents [MAX_KEYS];
  logic [MAX_KEYS-1:0] eqv, ltv, usedv, selv, shin, shout;
  logic [MAX_KEYS:0]   ltx;
  skt_pkg::bcast_t bc;
  skt_pkg::entry_t moved, zero_ent;

  // Search results and their registered copies.
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [CW-1:0] below;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [CW-1:0] below_r;

  assign cfg.ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      bezier_code <= 3'd2;
      custom_curve_code <= 3'd3;
    end else if (cfg.valid) begin
      if (cfg.data.index == skt_pkg::CFG_BEZIER) bezier_code <= cfg.data.value;
      else custom_curve_code <= cfg.data.value;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_KEYS; i++) usedv[i] = (CW'(i) < count);
  end

  assign zero_ent = '0;
  genvar g;
  generate
    for (g = 0; g < MAX_KEYS; g++) begin : gen_cell
      skt_cell u_cell (
        .clk(clk), .rst(rst), .bc(bc), .sel(selv[g]),
        .shift_in(shin[g]), .shift_out(shout[g]),
        .left((g == 0) ? zero_ent : ents[(g == 0) ? 0 : g-1]),
        .right((g == MAX_KEYS-1) ? zero_ent : ents[(g == MAX_KEYS-1) ? g : g+1]),
        .used(usedv[g]), .ent(ents[g]), .eq(eqv[g]), .lt(ltv[g])
      );
    end
  endgenerate

  // Sorted order makes the less-than flags a thermometer; the cell at its top
  // edge gives the insertion point, and the one-hot equal flag gives the hit index.
  always_comb begin
    hit = |eqv;
    hit_idx = '0;
    below = '0;
    ltx = {1'b0, ltv};
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (eqv[i]) hit_idx = IW'(i);
      if (ltx[i] && !ltx[i+1]) below = CW'(i + 1);
    end
  end

  logic [31:0] cur_key;
  always_comb begin
    cur_key = req.key_time;
    if (state == skt_pkg::S_SEARCH2 || state == skt_pkg::S_EXEC2) cur_key = req.dest_time;
  end

  always_comb begin
    state_next = state;
    case (state)
      skt_pkg::S_IDLE:    if (in_ch.valid) state_next = skt_pkg::S_SEARCH;
      skt_pkg::S_SEARCH:  state_next = skt_pkg::S_EXEC;
      skt_pkg::S_EXEC: begin
        if (req.action == skt_pkg::ACT_MOVE && hit_r && req.key_time != req.dest_time)
          state_next = skt_pkg::S_SEARCH2;
        else state_next = skt_pkg::S_DONE;
      end
      skt_pkg::S_SEARCH2: state_next = skt_pkg::S_EXEC2;
      skt_pkg::S_EXEC2:   state_next = skt_pkg::S_DONE;
      skt_pkg::S_DONE:    if (!out_valid || out_ch.ready) state_next = skt_pkg::S_IDLE;
      default:            state_next = skt_pkg::S_IDLE;
    endcase
  end

  // Cell commands. Move first erases the source (capturing its entry); a key
  // already at the destination is then overwritten in place.
  always_comb begin
    bc = '0;
    bc.key = cur_key;
    selv = '0;
    shin = '0;
    shout = '0;
    if (state == skt_pkg::S_EXEC) begin
      case (req.action)
        skt_pkg::ACT_SET: begin
          if (hit_r) begin
            bc.op = skt_pkg::OP_SETVAL;
            selv[hit_idx_r] = 1'b1;
            bc.ent.v = req.key_value;
          end else if (count < CW'(MAX_KEYS)) begin
            bc.op = skt_pkg::OP_INSERT;
            bc.ent.t = req.key_time;
            bc.ent.v = req.key_value;
            bc.ent.c = req.interp_code;
            for (int i = 0; i < MAX_KEYS; i++) begin
              selv[i] = (CW'(i) == below_r);
              shin[i] = (CW'(i) > below_r);
            end
          end
        end
        skt_pkg::ACT_REM, skt_pkg::ACT_MOVE: begin
          if (hit_r && (req.action == skt_pkg::ACT_REM || req.key_time != req.dest_time)) begin
            bc.op = skt_pkg::OP_ERASE;
            for (int i = 0; i < MAX_KEYS; i++) shout[i] = (IW'(i) >= hit_idx_r);
          end
        end
        skt_pkg::ACT_CURVE: begin
          if (hit_r) begin
            bc.op = skt_pkg::OP_CURVE;
            selv[hit_idx_r] = 1'b1;
            bc.ent.c = req.interp_code;
            bc.ent.x1 = req.ctrl_x1;
            bc.ent.y1 = req.ctrl_y1;
            bc.ent.x2 = req.ctrl_x2;
            bc.ent.y2 = req.ctrl_y2;
            bc.wr_ctrl = (req.interp_code == bezier_code) ||
                         (req.interp_code == custom_curve_code);
          end
        end
        default: ;
      endcase
    end else if (state == skt_pkg::S_EXEC2) begin
      bc.ent = moved;
      bc.ent.t = req.dest_time;
      if (hit_r) begin
        // Overwrite all fields of the existing destination entry.
        bc.op = skt_pkg::OP_INSERT;
        selv[hit_idx_r] = 1'b1;
      end else begin
        bc.op = skt_pkg::OP_INSERT;
        for (int i = 0; i < MAX_KEYS; i++) begin
          selv[i] = (CW'(i) == below_r);
          shin[i] = (CW'(i) > below_r);
        end
      end
    end
  end

  // Result fields and key count for the execute steps.
  always_comb begin
    st_next = st;
    idx_next = idx;
    count_next = count;
    if (state == skt_pkg::S_EXEC) begin
      st_next = skt_pkg::ST_NONE;
      idx_next = '0;
      case (req.action)
        skt_pkg::ACT_FIND: if (hit_r) begin
          st_next = skt_pkg::ST_OK; idx_next = hit_idx_r;
        end
        skt_pkg::ACT_FLOOR: begin
          if (hit_r) begin st_next = skt_pkg::ST_OK; idx_next = hit_idx_r; end
          else if (below_r != '0) begin
            st_next = skt_pkg::ST_OK;
            idx_next = IW'(below_r - CW'(1));
          end
        end
        skt_pkg::ACT_SET: begin
          if (hit_r) begin st_next = skt_pkg::ST_OK; idx_next = hit_idx_r; end
          else if (count < CW'(MAX_KEYS)) begin
            st_next = skt_pkg::ST_OK;
            idx_next = IW'(below_r);
            count_next = count + CW'(1);
          end else st_next = skt_pkg::ST_FULL;
        end
        skt_pkg::ACT_REM: if (hit_r) begin
          st_next = skt_pkg::ST_OK; idx_next = hit_idx_r; count_next = count - CW'(1);
        end
        skt_pkg::ACT_MOVE: if (hit_r) begin
          st_next = skt_pkg::ST_OK; idx_next = hit_idx_r;
          if (req.key_time != req.dest_time) count_next = count - CW'(1);
        end
        skt_pkg::ACT_CURVE: if (hit_r) begin
          st_next = skt_pkg::ST_OK; idx_next = hit_idx_r;
        end
        default: ;
      endcase
    end else if (state == skt_pkg::S_EXEC2) begin
      st_next = skt_pkg::ST_OK;
      if (hit_r) idx_next = hit_idx_r;
      else begin
        idx_next = IW'(below_r);
        count_next = count + CW'(1);
      end
    end
  end

  assign in_ch.ready = (state == skt_pkg::S_IDLE) && !rst;
  assign out_ch.valid = out_valid;
  assign out_ch.data.status = st;
  assign out_ch.data.entry_index = 6'(idx);
  assign out_ch.data.entry_count = 7'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skt_pkg::S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      st <= st_next;
      idx <= idx_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (state == skt_pkg::S_IDLE && in_ch.valid) req <= in_ch.data;
      if (state == skt_pkg::S_SEARCH || state == skt_pkg::S_SEARCH2) begin
        hit_r <= hit;
        hit_idx_r <= hit_idx;
        below_r <= below;
      end
      if (state == skt_pkg::S_EXEC) moved <= ents[hit_idx_r];
      if (state_next == skt_pkg::S_DONE && state != skt_pkg::S_DONE) out_valid <= 1'b1;
    end
  end
endmodule

### sv/skt_checker.sv
// Port-level checker for the keyframe table, bound to the top level.
// Depends on skt_pkg and sorted_keyframe_table_unit_macros.svh.
`include "sorted_keyframe_table_unit_macros.svh"
module skt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [6:0] entry_count
);
  `SKT_ASSERT_IMP(a_full_count, clk, rst, out_valid && status == skt_pkg::ST_FULL, entry_count != 7'd0)
  `SKT_ASSERT_IMP(a_busy, clk, rst, out_valid, !in_ready)
  `SKT_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  `SKT_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))
endmodule

bind sorted_keyframe_table_unit skt_checker u_skt_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.data.status), .entry_count(out_ch.data.entry_count)
);

### sim/tb_top.sv
// Self-checking testbench of the sorted keyframe table (sorted_keyframe_table_unit).
// Depends on skt_pkg and skt_if; a scoreboard class predicts each result word.
`timescale 1ns / 1ps

module tb_top;
  localparam int NumKeys = 64;
  localparam int IdleLimit = 5000;

  typedef struct {
    logic signed [31:0] t;
    logic [31:0] v;
    logic [2:0] c;
    logic [31:0] x1, y1, x2, y2;
  } key_t;

  class keyframe_scoreboard;
    key_t   keys[NumKeys];
    int     key_count;
    logic [2:0] bezier_code, custom_code;
    skt_pkg::reply_t replies[$];
    int     mismatches;

    function void clear();
      key_count = 0;
      bezier_code = 3'd2;
      custom_code = 3'd3;
      replies.delete();
      mismatches = 0;
    endfunction

    function void set_code(logic index, logic [2:0] data);
      if (index == skt_pkg::CFG_BEZIER) bezier_code = data;
      else custom_code = data;
    endfunction

    function bit lookup(logic signed [31:0] t, output int pos);
      pos = 0;
      for (int i = 0; i < key_count; i++) begin
        if (keys[i].t == t) begin
          pos = i;
          return 1;
        end
      end
      return 0;
    endfunction

    function int first_at_or_after(logic signed [31:0] t);
      int i;
      i = 0;
      while (i < key_count && keys[i].t < t) i++;
      return i;
    endfunction

    function void erase(int pos);
      for (int i = pos; i + 1 < key_count; i++) keys[i] = keys[i+1];
      key_count--;
    endfunction

    function void insert(int pos, key_t k);
      for (int i = key_count; i > pos; i--) keys[i] = keys[i-1];
      keys[pos] = k;
      key_count++;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    // Applies one accepted edit word to the shadow table and queues its reply.
    function void note_edit(skt_pkg::edit_t e);
      skt_pkg::reply_t r;
      int p, q;
      key_t k;
      logic signed [31:0] t, d;
      t = e.key_time;
      d = e.dest_time;
      r.status = skt_pkg::ST_NONE;
      r.entry_index = '0;
      case (e.action)
        skt_pkg::ACT_FIND: if (lookup(t, p)) begin
          r.status = skt_pkg::ST_OK; r.entry_index = 6'(p);
        end
        skt_pkg::ACT_FLOOR: if (key_count != 0 && t >= keys[0].t) begin
          p = 0;
          while (p + 1 < key_count && keys[p+1].t <= t) p++;
          r.status = skt_pkg::ST_OK; r.entry_index = 6'(p);
        end
        skt_pkg::ACT_SET: if (lookup(t, p)) begin
          keys[p].v = e.key_value;
          r.status = skt_pkg::ST_OK; r.entry_index = 6'(p);
        end else if (key_count >= NumKeys) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          k = '{t, e.key_value, e.interp_code, 0, 0, 0, 0};
          p = first_at_or_after(t);
          insert(p, k);
          r.status = skt_pkg::ST_OK; r.entry_index = 6'(p);
        end
        skt_pkg::ACT_REM: if (lookup(t, p)) begin
          erase(p);
          r.status = skt_pkg::ST_OK; r.entry_index = 6'(p);
        end
        skt_pkg::ACT_MOVE: if (t == d) begin
          if (lookup(t, p)) begin
            r.status = skt_pkg::ST_OK; r.entry_index = 6'(p);
          end
        end else if (lookup(t, p)) begin
          k = keys[p];
          k.t = d;
          erase(p);
          if (lookup(d, q)) erase(q);
          q = first_at_or_after(d);
          insert(q, k);
          r.status = skt_pkg::ST_OK; r.entry_index = 6'(q);
        end
        skt_pkg::ACT_CURVE: if (lookup(t, p)) begin
          keys[p].c = e.interp_code;
          if (e.interp_code == bezier_code || e.interp_code == custom_code) begin
            keys[p].x1 = e.ctrl_x1; keys[p].y1 = e.ctrl_y1;
            keys[p].x2 = e.ctrl_x2; keys[p].y2 = e.ctrl_y2;
          end
          r.status = skt_pkg::ST_OK; r.entry_index = 6'(p);
        end
        default: ;
      endcase
      r.entry_count = 7'(key_count);
      replies = {replies, r};
    endfunction

    function void check_reply(skt_pkg::reply_t got);
      skt_pkg::reply_t want;
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = replies.pop_front();
      if (got.status !== want.status || got.entry_index !== want.entry_index ||
          got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  skt_if #(.T(skt_pkg::cfg_t))   cfg();
  skt_if #(.T(skt_pkg::edit_t))  in_ch();
  skt_if #(.T(skt_pkg::reply_t)) out_ch();

  sorted_keyframe_table_unit #(.MAX_KEYS(NumKeys)) dut (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
  );

  keyframe_scoreboard sb = new();
  logic [31:0] time_pool[72];
  int idle_cycles;
  bit stall_free;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if (stall_free) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(5, 25);
    return $urandom_range(0, 2);
  endfunction

  // Result side: random backpressure, checked at every accepting edge.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    hold = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_ch.valid && out_ch.ready) sb.check_reply(out_ch.data);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        hold = gap_len();
        out_ch.ready <= (hold == 0);
      end
      @(posedge clk);
    end
  end

  // Watchdog on cycles without any accepted word.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg.valid && cfg.ready) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_edit(skt_pkg::edit_t e);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= e;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_edit(e);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_code(logic index, logic [2:0] data);
    cfg.valid <= 1'b1;
    cfg.data <= '{index, data};
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.set_code(index, data);
  endtask

  function automatic skt_pkg::edit_t make_edit(logic [2:0] a, logic [31:0] t,
                                               logic [31:0] d, logic [2:0] code);
    skt_pkg::edit_t e;
    e.action = a;
    e.key_time = t;
    e.dest_time = d;
    e.key_value = $urandom();
    e.interp_code = code;
    e.ctrl_x1 = $urandom();
    e.ctrl_y1 = $urandom();
    e.ctrl_x2 = $urandom();
    e.ctrl_y2 = $urandom();
    return e;
  endfunction

  function automatic logic [31:0] pick_time();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return time_pool[$urandom_range(0, 71)];
  endfunction

  // set_weight is out of 100; the rest picks any action, set too, or an unused code.
  task automatic random_phase(int count, int set_weight);
    skt_pkg::edit_t e;
    int r;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) stall_free = ($urandom_range(0, 3) == 0);
      e = make_edit(skt_pkg::ACT_FIND, pick_time(), pick_time(), 3'($urandom_range(0, 7)));
      r = $urandom_range(0, 99);
      if (r < set_weight) e.action = skt_pkg::ACT_SET;
      else if (r >= 97) e.action = 3'($urandom_range(6, 7));
      else e.action = 3'($urandom_range(0, 5));
      send_edit(e);
    end
    stall_free = 1'b0;
    drain();
  endtask

  initial begin
    logic [31:0] tmin, tmax;
    tmin = 32'h8000_0000;
    tmax = 32'h7fff_ffff;
    sb.clear();
    stall_free = 1'b0;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int i = 0; i < 72; i++) time_pool[i] = $urandom();
    time_pool[0] = tmin;
    time_pool[1] = tmax;
    time_pool[2] = 32'd0;
    time_pool[3] = 32'hffff_ffff;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: every lookup misses, floor included.
    send_edit(make_edit(skt_pkg::ACT_FLOOR, 32'd0, 32'd0, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_FIND, 32'd100, 32'd0, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_REM, 32'd100, 32'd0, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_MOVE, 32'd100, 32'd200, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_CURVE, 32'd100, 32'd0, 3'd2));
    send_edit(make_edit(skt_pkg::ACT_SET, 32'd100, 32'd0, 3'd1));
    send_edit(make_edit(skt_pkg::ACT_FLOOR, 32'd50, 32'd0, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_SET, tmin, 32'd0, 3'd7));
    send_edit(make_edit(skt_pkg::ACT_SET, tmax, 32'd0, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_SET, 32'd100, 32'd0, 3'd4));
    send_edit(make_edit(skt_pkg::ACT_FIND, tmax, 32'd0, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_FLOOR, 32'd200, 32'd0, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_CURVE, 32'd100, 32'd0, 3'd2));
    send_edit(make_edit(skt_pkg::ACT_CURVE, 32'd100, 32'd0, 3'd5));
    send_edit(make_edit(skt_pkg::ACT_CURVE, tmin, 32'd0, 3'd3));
    send_edit(make_edit(skt_pkg::ACT_MOVE, 32'd100, 32'd100, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_MOVE, 32'd100, 32'd200, 3'd0));
    // Moving onto an occupied time drops the key that was there.
    send_edit(make_edit(skt_pkg::ACT_MOVE, tmax, 32'd200, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_MOVE, 32'd999, 32'd5, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_REM, tmin, 32'd0, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_REM, 32'd777, 32'd0, 3'd0));
    send_edit(make_edit(3'd6, 32'd200, 32'd0, 3'd0));
    send_edit(make_edit(3'd7, 32'd200, 32'd0, 3'd0));
    send_edit(make_edit(skt_pkg::ACT_FLOOR, tmax, 32'd0, 3'd0));
    drain();

    // Set-heavy first so the table fills and refuses inserts.
    random_phase(200, 60);
    write_code(skt_pkg::CFG_BEZIER, 3'd7);
    write_code(skt_pkg::CFG_CUSTOM, 3'd0);
    random_phase(200, 30);
    write_code(skt_pkg::CFG_BEZIER, 3'd5);
    write_code(skt_pkg::CFG_CUSTOM, 3'd5);
    random_phase(100, 40);
    write_code(skt_pkg::CFG_BEZIER, 3'd0);
    write_code(skt_pkg::CFG_CUSTOM, 3'd7);
    random_phase(100, 35);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
